// ----- hdl/lkvc_pkg.sv -----
// Shared constants, codes and types for the LRU key-value cache.
package lkvc_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam int MAX_ENTRIES_DEF = 16;
   localparam int ADDR_W_DEF      = 4;

   localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
   localparam logic [VAL_W-1:0] MISS_VALUE     = '1;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } kv_entry_type;

endpackage

// ----- hdl/lkvc_req_if.sv -----
// Request channel: get/set beats into the cache.
interface lkvc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              kind;
   logic signed [lkvc_pkg::KEY_W-1:0] key;
   logic signed [lkvc_pkg::VAL_W-1:0] value;

   modport source (output valid, output kind, output key, output value, input ready);
   modport sink   (input valid, input kind, input key, input value, output ready);
endinterface

// ----- hdl/lkvc_rsp_if.sv -----
// Response channel: one beat per get.
interface lkvc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              hit;
   logic signed [lkvc_pkg::VAL_W-1:0] read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

// ----- hdl/lkvc_mem.sv -----
// Key/value storage RAM, one write and one registered read port.
module lkvc_mem #(
   parameter int DEPTH  = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_W = lkvc_pkg::ADDR_W_DEF
) (
   input  logic                   clock,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output lkvc_pkg::kv_entry_type rd_data,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  lkvc_pkg::kv_entry_type wr_data
);

   lkvc_pkg::kv_entry_type mem_ff [DEPTH];
   lkvc_pkg::kv_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/lkvc_ctrl.sv -----
// Scan sequencer, recency ranks, occupancy, capacity register and response register.
module lkvc_ctrl #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF,
   parameter int ADDR_W      = lkvc_pkg::ADDR_W_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lkvc_req_if.sink                          req_ch,
   lkvc_rsp_if.source                        rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0]        csr_wr_data,
   output logic                              mem_rd_en,
   output logic [ADDR_W-1:0]                 mem_rd_addr,
   input  lkvc_pkg::kv_entry_type            mem_rd_data,
   output logic                              mem_wr_en,
   output logic [ADDR_W-1:0]                 mem_wr_addr,
   output lkvc_pkg::kv_entry_type            mem_wr_data
);

   localparam int RANK_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int OCC_W  = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_LAST   = 2'd2;
   localparam logic [1:0] ST_UPDATE = 2'd3;

   logic [1:0]                   state_ff, state_in;
   logic [ADDR_W-1:0]            idx_ff, idx_in;
   logic [ADDR_W-1:0]            chk_idx_ff, chk_idx_in;
   logic                         chk_vld_ff, chk_vld_in;
   logic                         kind_ff, kind_in;
   logic [lkvc_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [lkvc_pkg::VAL_W-1:0]   val_ff, val_in;
   logic                         hit_found_ff, hit_found_in;
   logic [ADDR_W-1:0]            hit_slot_ff, hit_slot_in;
   logic [RANK_W-1:0]            hit_rank_ff, hit_rank_in;
   logic [lkvc_pkg::VAL_W-1:0]   hit_val_ff, hit_val_in;
   logic                         free_found_ff, free_found_in;
   logic [ADDR_W-1:0]            free_slot_ff, free_slot_in;
   logic [ADDR_W-1:0]            lru_slot_ff, lru_slot_in;
   logic [MAX_ENTRIES-1:0]       valid_ff, valid_in;
   logic [RANK_W-1:0]            rank_ff [MAX_ENTRIES];
   logic [RANK_W-1:0]            rank_in [MAX_ENTRIES];
   logic [OCC_W-1:0]             occ_ff, occ_in;
   logic [lkvc_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_hit_in;
   logic [lkvc_pkg::VAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic [RANK_W-1:0]            occ_m1;
   logic [CMP_W-1:0]             cap_x, eff_cap, occ_x;
   logic                         proceed;
   logic                         do_upd;
   logic                         tgt_new;   // target slot was free: every valid entry ages
   logic                         tgt_fresh; // new entry takes a free slot
   logic [ADDR_W-1:0]            tgt_slot;
   logic [RANK_W-1:0]            tgt_rank;

   assign occ_m1 = RANK_W'(occ_ff - OCC_W'(1));
   assign cap_x  = CMP_W'(cap_ff);
   assign occ_x  = CMP_W'(occ_ff);

   always_comb begin
      if (cap_x == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_x > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_x;
      end
   end

   // replacement decision, valid once the scan is done
   always_comb begin
      do_upd    = 1'b1;
      tgt_new   = 1'b0;
      tgt_fresh = 1'b0;
      tgt_slot  = hit_slot_ff;
      tgt_rank  = hit_rank_ff;
      if (hit_found_ff) begin
         tgt_slot = hit_slot_ff;
         tgt_rank = hit_rank_ff;
      end else if (kind_ff == lkvc_pkg::OP_SET) begin
         if ((occ_x >= eff_cap) || !free_found_ff) begin
            tgt_slot = lru_slot_ff;
            tgt_rank = occ_m1;
         end else begin
            tgt_slot  = free_slot_ff;
            tgt_new   = 1'b1;
            tgt_fresh = 1'b1;
         end
      end else begin
         do_upd = 1'b0;
      end
   end

   assign proceed = (kind_ff == lkvc_pkg::OP_SET) || !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      chk_idx_in    = chk_idx_ff;
      chk_vld_in    = chk_vld_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      hit_found_in  = hit_found_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      hit_val_in    = hit_val_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      lru_slot_in   = lru_slot_ff;
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      occ_in        = occ_ff;
      cap_in        = cap_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_hit_in    = rsp_hit_ff;
      rsp_value_in  = rsp_value_ff;

      if (csr_wr_en) begin
         cap_in = csr_wr_data;
      end
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      // key compare on the word read last cycle
      if (chk_vld_ff && valid_ff[chk_idx_ff] && !hit_found_ff &&
          (mem_rd_data.key == key_ff)) begin
         hit_found_in = 1'b1;
         hit_slot_in  = chk_idx_ff;
         hit_rank_in  = rank_ff[chk_idx_ff];
         hit_val_in   = mem_rd_data.value;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               kind_in       = req_ch.kind;
               key_in        = req_ch.key;
               val_in        = req_ch.value;
               idx_in        = '0;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_idx_in = idx_ff;
            chk_vld_in = 1'b1;
            idx_in     = idx_ff + ADDR_W'(1);
            if (!free_found_ff && !valid_ff[idx_ff]) begin
               free_found_in = 1'b1;
               free_slot_in  = idx_ff;
            end
            if (valid_ff[idx_ff] && (rank_ff[idx_ff] == occ_m1)) begin
               lru_slot_in = idx_ff;
            end
            if (idx_ff == ADDR_W'(MAX_ENTRIES - 1)) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            chk_vld_in = 1'b0;
            state_in   = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (proceed) begin
               state_in = ST_IDLE;
               if (do_upd) begin
                  for (int i = 0; i < MAX_ENTRIES; i++) begin
                     if (ADDR_W'(i) == tgt_slot) begin
                        rank_in[i] = '0;
                     end else if (valid_ff[i] && (tgt_new || (rank_ff[i] < tgt_rank))) begin
                        rank_in[i] = rank_ff[i] + RANK_W'(1);
                     end
                  end
                  valid_in[tgt_slot] = 1'b1;
               end
               if (tgt_fresh) begin
                  occ_in = occ_ff + OCC_W'(1);
               end
               if (kind_ff == lkvc_pkg::OP_GET) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = hit_found_ff;
                  rsp_value_in = hit_found_ff ? hit_val_ff : lkvc_pkg::MISS_VALUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         occ_ff       <= '0;
         cap_ff       <= lkvc_pkg::CAPACITY_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
      end
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      hit_found_ff  <= hit_found_in;
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      hit_val_ff    <= hit_val_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      lru_slot_ff   <= lru_slot_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign req_ch.ready      = (state_ff == ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_hit_ff;
   assign rsp_ch.read_value = rsp_value_ff;

   assign mem_rd_en        = (state_ff == ST_SCAN);
   assign mem_rd_addr      = idx_ff;
   assign mem_wr_en        = (state_ff == ST_UPDATE) && proceed &&
                             (kind_ff == lkvc_pkg::OP_SET);
   assign mem_wr_addr      = tgt_slot;
   assign mem_wr_data.key   = key_ff;
   assign mem_wr_data.value = val_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(MAX_ENTRIES))
      else $error("occupancy above entry count");

   a_occ_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(occ_ff))
      else $error("occupancy out of step with valid bits");

   a_set_lands_mru: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && proceed && kind_ff == lkvc_pkg::OP_SET) |=>
      (valid_ff[$past(tgt_slot)] && rank_ff[$past(tgt_slot)] == '0))
      else $error("set did not leave its slot valid and most recent");

   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_value_ff == lkvc_pkg::MISS_VALUE))
      else $error("miss beat without all-ones value");
`endif

endmodule

// ----- hdl/lru_key_value_cache_top.sv -----
// A get's response is registered from the update state, after the scan and compare states.
// One beat at a time: a request is taken only in idle, so the next waits for the
// key/value RAM scan, one entry read per cycle, and the compare and update states.
// A response left waiting holds the next get in its update cycle; sets are not held.
// Reset (synchronous, active high): cache empty, capacity 16; valid bits clear at
// once, RAM needs no clearing pass.
module lru_key_value_cache_top #(
   parameter int MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   lkvc_req_if.sink                   req_ch,
   lkvc_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [lkvc_pkg::CAP_W-1:0] csr_wr_data
);

   localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   logic                   mem_rd_en;
   logic [ADDR_W-1:0]      mem_rd_addr;
   lkvc_pkg::kv_entry_type mem_rd_data;
   logic                   mem_wr_en;
   logic [ADDR_W-1:0]      mem_wr_addr;
   lkvc_pkg::kv_entry_type mem_wr_data;

   lkvc_ctrl #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_W      (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   lkvc_mem #(
      .DEPTH  (MAX_ENTRIES),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule
